// File: rtl/cchd_pkg.sv
package cchd_pkg;

  localparam int TABLE_SIZE   = 16;
  localparam int KEY_BYTES    = 8;
  localparam int SLOT_W       = $clog2(TABLE_SIZE);
  localparam int LINK_W       = SLOT_W + 1;
  localparam int STEP_W       = $clog2(TABLE_SIZE + 1);
  localparam int FUNC_W       = 2;
  localparam int KEY_W        = 64;
  localparam int LEN_W        = 4;
  localparam int VAL_W        = 40;
  localparam int STAT_W       = 3;
  localparam int SLOT_FIELD_W = 4;

  localparam logic [LINK_W-1:0] LINK_NONE = LINK_W'(1) << SLOT_W;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_HOME     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_OVERFLOW = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 3'd2;
  localparam logic [STAT_W-1:0] STAT_FOUND    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_MISSING  = 3'd4;
  localparam logic [STAT_W-1:0] STAT_DELETED  = 3'd5;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [LEN_W-1:0]  key_len;
    logic [VAL_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [VAL_W-1:0]        value_out;
    logic [SLOT_FIELD_W-1:0] slot;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_INS_HOME,
    CMD_INS_FREE,
    CMD_FULL,
    CMD_STEP,
    CMD_INS_LINK,
    CMD_FOUND,
    CMD_DEL,
    CMD_MISS
  } cmd_e;

  typedef struct packed {
    cmd_e op;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              home_free;
    logic              full;
    logic              next_none;
    logic              cur_none;
    logic              match;
    logic              steps_done;
  } dp_status_t;

endpackage

// File: rtl/coalesced_chain_hash_dictionary.sv
// Key/value dictionary over a 16-slot table with coalesced chaining. Each input
// item is an insert, find or delete; each gives exactly one result item. The home
// slot is the key length (saturated to 8) modulo the table size. An item ends
// at the home check when it is a home insert, hits a full table or has an
// unknown op; otherwise it walks the chain, which reads one link of the link
// table per cycle and follows at most 16 links. One item is processed at a
// time; a finished result sits in an output register, so the next item is
// accepted while it waits to be taken. Reset clears all slots at once.
module coalesced_chain_hash_dictionary import cchd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cchd_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  cchd_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_item_o (out_item_o)
  );

endmodule

// File: rtl/cchd_datapath.sv
module cchd_datapath import cchd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  in_item_t   in_item_i,
  input  ctrl_cmd_t  cmd_i,
  output dp_status_t status_o,
  output out_item_t  out_item_o
);

  logic [FUNC_W-1:0] func_q;
  logic [KEY_W-1:0]  key_q;
  logic [LEN_W-1:0]  len_q;
  logic [VAL_W-1:0]  val_q;
  logic [LINK_W-1:0] cur_q, cur_d;
  logic [LINK_W-1:0] prev_q, prev_d;
  logic [STEP_W-1:0] steps_q, steps_d;
  logic [SLOT_W-1:0] free_q;
  out_item_t         res_q, res_d;
  out_item_t         out_q;

  logic [TABLE_SIZE-1:0] valid_q;
  logic [LINK_W-1:0]     link_q [TABLE_SIZE];
  logic [KEY_W-1:0]      key_mem [TABLE_SIZE];
  logic [LEN_W-1:0]      len_mem [TABLE_SIZE];
  logic [VAL_W-1:0]      val_mem [TABLE_SIZE];

  logic [LEN_W-1:0]  in_len;
  logic [KEY_W-1:0]  in_key;
  logic [SLOT_W-1:0] in_home;
  logic [SLOT_W-1:0] home;
  logic [SLOT_W-1:0] cur_idx;
  logic [SLOT_W-1:0] prev_idx;
  logic [LINK_W-1:0] next_raw;
  logic [SLOT_W-1:0] free_idx;
  logic              free_found;

  always_comb begin
    in_len = (in_item_i.key_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : in_item_i.key_len;
    for (int b = 0; b < KEY_W / 8; b++) begin
      in_key[8*b +: 8] = (b < int'(in_len)) ? in_item_i.key[8*b +: 8] : 8'd0;
    end
    in_home = SLOT_W'(32'(in_len) % TABLE_SIZE);
  end

  assign home     = SLOT_W'(32'(len_q) % TABLE_SIZE);
  assign cur_idx  = cur_q[SLOT_W-1:0];
  assign prev_idx = prev_q[SLOT_W-1:0];
  assign next_raw = link_q[cur_idx];

  // lowest empty slot
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx   = SLOT_W'(i);
        free_found = 1'b1;
      end
    end
  end

  always_comb begin
    status_o.func       = func_q;
    status_o.home_free  = !valid_q[home];
    status_o.full       = !free_found;
    status_o.next_none  = next_raw[SLOT_W];
    status_o.cur_none   = cur_q[SLOT_W];
    status_o.match      = !cur_q[SLOT_W] && valid_q[cur_idx] &&
                          (key_mem[cur_idx] == key_q) && (len_mem[cur_idx] == len_q);
    status_o.steps_done = (steps_q == STEP_W'(TABLE_SIZE));
  end

  always_comb begin
    cur_d   = cur_q;
    prev_d  = prev_q;
    steps_d = steps_q;
    res_d   = res_q;
    case (cmd_i.op)
      CMD_LOAD: begin
        cur_d   = {1'b0, in_home};
        prev_d  = LINK_NONE;
        steps_d = '0;
      end
      CMD_STEP: begin
        prev_d  = cur_q;
        cur_d   = next_raw;
        steps_d = steps_q + STEP_W'(1);
      end
      CMD_INS_HOME: res_d = '{STAT_HOME, '0, SLOT_FIELD_W'(home)};
      CMD_FULL:     res_d = '{STAT_FULL, '0, '0};
      CMD_INS_LINK: res_d = '{STAT_OVERFLOW, '0, SLOT_FIELD_W'(free_q)};
      CMD_FOUND:    res_d = '{STAT_FOUND, val_mem[cur_idx], SLOT_FIELD_W'(cur_idx)};
      CMD_DEL:      res_d = '{STAT_DELETED, '0, SLOT_FIELD_W'(cur_idx)};
      CMD_MISS:     res_d = '{STAT_MISSING, '0, '0};
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q   <= LINK_NONE;
      prev_q  <= LINK_NONE;
      steps_q <= '0;
      valid_q <= '0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        link_q[i] <= LINK_NONE;
      end
    end else begin
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      steps_q <= steps_d;
      case (cmd_i.op)
        CMD_INS_HOME: valid_q[home] <= 1'b1;
        CMD_INS_LINK: begin
          valid_q[free_q]  <= 1'b1;
          link_q[cur_idx]  <= {1'b0, free_q};
        end
        CMD_DEL: begin
          valid_q[cur_idx] <= 1'b0;
          if (!prev_q[SLOT_W]) begin
            link_q[prev_idx] <= next_raw;
          end
          link_q[cur_idx]  <= LINK_NONE;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (cmd_i.out_load) begin
      out_q <= res_q;
    end
    case (cmd_i.op)
      CMD_LOAD: begin
        func_q <= in_item_i.func;
        key_q  <= in_key;
        len_q  <= in_len;
        val_q  <= in_item_i.value;
      end
      CMD_INS_FREE: free_q <= free_idx;
      CMD_INS_HOME: begin
        key_mem[home] <= key_q;
        len_mem[home] <= len_q;
        val_mem[home] <= val_q;
      end
      CMD_INS_LINK: begin
        key_mem[free_q] <= key_q;
        len_mem[free_q] <= len_q;
        val_mem[free_q] <= val_q;
      end
      default: ;
    endcase
  end

  assign out_item_o = out_q;

  a_steps_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= STEP_W'(TABLE_SIZE))
    else $error("walk step count past table size");

  a_del_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == CMD_DEL |=> !valid_q[$past(cur_idx)] && link_q[$past(cur_idx)] == LINK_NONE)
    else $error("deleted slot still valid or linked");

  a_ins_link: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.op == CMD_INS_LINK |=>
      valid_q[$past(free_q)] && link_q[$past(cur_idx)] == {1'b0, $past(free_q)})
    else $error("overflow insert not stored or linked");

endmodule

// File: rtl/cchd_controller.sv
module cchd_controller import cchd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WALK = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    out_valid_d    = out_valid_q && !out_ready_i;
    cmd_o.op       = CMD_NONE;
    cmd_o.out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = CMD_LOAD;
          state_d  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status_i.func)
          FUNC_INSERT: begin
            if (status_i.home_free) begin
              cmd_o.op = CMD_INS_HOME;
              state_d  = ST_DONE;
            end else if (status_i.full) begin
              cmd_o.op = CMD_FULL;
              state_d  = ST_DONE;
            end else begin
              cmd_o.op = CMD_INS_FREE;
              state_d  = ST_WALK;
            end
          end
          FUNC_FIND, FUNC_DELETE: state_d = ST_WALK;
          default: begin
            cmd_o.op = CMD_MISS;
            state_d  = ST_DONE;
          end
        endcase
      end
      ST_WALK: begin
        if (status_i.func == FUNC_INSERT) begin
          if (status_i.steps_done || status_i.next_none) begin
            cmd_o.op = CMD_INS_LINK;
            state_d  = ST_DONE;
          end else begin
            cmd_o.op = CMD_STEP;
          end
        end else if (status_i.steps_done || status_i.cur_none) begin
          cmd_o.op = CMD_MISS;
          state_d  = ST_DONE;
        end else if (status_i.match) begin
          cmd_o.op = (status_i.func == FUNC_DELETE) ? CMD_DEL : CMD_FOUND;
          state_d  = ST_DONE;
        end else begin
          cmd_o.op = CMD_STEP;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in progress");

endmodule

// File: sim/cchd_tb_pkg.sv
`timescale 1ns / 1ps
package cchd_tb_pkg;
  import cchd_pkg::*;

  class dict_scoreboard;
    bit                occupied   [TABLE_SIZE];
    logic [KEY_W-1:0]  stored_key [TABLE_SIZE];
    logic [LEN_W-1:0]  stored_len [TABLE_SIZE];
    logic [VAL_W-1:0]  stored_val [TABLE_SIZE];
    logic [LINK_W-1:0] chain_next [TABLE_SIZE];
    out_item_t         expected_replies [$];
    int unsigned       fail_count;

    function new();
      foreach (occupied[i]) begin
        occupied[i]   = 1'b0;
        chain_next[i] = LINK_NONE;
      end
      fail_count = 0;
    endfunction

    function out_item_t apply_dict_op(in_item_t it);
      logic [LEN_W-1:0]  len;
      logic [KEY_W-1:0]  key;
      logic [LINK_W-1:0] home;
      logic [LINK_W-1:0] cur;
      logic [LINK_W-1:0] prev;
      logic [LINK_W-1:0] free_slot;
      out_item_t         r;
      len = (it.key_len > KEY_BYTES) ? LEN_W'(KEY_BYTES) : it.key_len;
      key = it.key;
      if (len < KEY_BYTES) key &= (KEY_W'(1) << (8 * len)) - KEY_W'(1);
      home = LINK_W'(len % TABLE_SIZE);
      r.status    = STAT_MISSING;
      r.value_out = '0;
      r.slot      = '0;
      case (it.func)
        FUNC_INSERT: begin
          if (!occupied[home]) begin
            occupied[home]   = 1'b1;
            stored_key[home] = key;
            stored_len[home] = len;
            stored_val[home] = it.value;
            r.status = STAT_HOME;
            r.slot   = home[SLOT_W-1:0];
            return r;
          end
          free_slot = LINK_NONE;
          for (int i = TABLE_SIZE - 1; i >= 0; i--) begin
            if (!occupied[i]) free_slot = LINK_W'(i);
          end
          if (free_slot == LINK_NONE) begin
            r.status = STAT_FULL;
            return r;
          end
          occupied[free_slot]   = 1'b1;
          stored_key[free_slot] = key;
          stored_len[free_slot] = len;
          stored_val[free_slot] = it.value;
          // tail search is bounded; a looped chain links from the last slot seen
          cur = home;
          for (int s = 0; s < TABLE_SIZE; s++) begin
            if (chain_next[cur] == LINK_NONE) break;
            cur = chain_next[cur];
          end
          chain_next[cur] = free_slot;
          r.status = STAT_OVERFLOW;
          r.slot   = free_slot[SLOT_W-1:0];
        end
        FUNC_FIND, FUNC_DELETE: begin
          cur  = home;
          prev = LINK_NONE;
          for (int s = 0; s < TABLE_SIZE && cur != LINK_NONE; s++) begin
            if (occupied[cur] && stored_key[cur] == key && stored_len[cur] == len) begin
              r.slot = cur[SLOT_W-1:0];
              if (it.func == FUNC_FIND) begin
                r.status    = STAT_FOUND;
                r.value_out = stored_val[cur];
              end else begin
                occupied[cur]   = 1'b0;
                stored_val[cur] = '0;
                // head removal leaves the rest of the chain unreachable
                if (prev != LINK_NONE) chain_next[prev] = chain_next[cur];
                chain_next[cur] = LINK_NONE;
                r.status = STAT_DELETED;
              end
              return r;
            end
            prev = cur;
            cur  = chain_next[cur];
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_request(in_item_t it);
      expected_replies.push_back(apply_dict_op(it));
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (expected_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: unexpected item: status %0d value %h slot %0d",
                   $time, got.status, got.value_out, got.slot);
        end
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status || got.value_out !== want.value_out ||
          got.slot !== want.slot) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: mismatch: exp status %0d value %h slot %0d, got status %0d value %h slot %0d",
                   $time, want.status, want.value_out, want.slot,
                   got.status, got.value_out, got.slot);
        end
      end
    endfunction
  endclass

endpackage

// File: sim/coalesced_chain_hash_dictionary_tb.sv
`timescale 1ns / 1ps
module coalesced_chain_hash_dictionary_tb;
  import cchd_pkg::*;
  import cchd_tb_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNDEF = 2'd3;
  localparam int RANDOM_ITEMS  = 1400;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 600000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  dict_scoreboard sb;
  bit             hold_req = 1'b0;
  int             burst_left = 0;
  int unsigned    cycle_count = 0;
  in_item_t       key_pool [$];

  coalesced_chain_hash_dictionary i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // results first: a result never belongs to the item taken on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) sb.check_reply(out_item_o);
      if (in_valid_i && in_ready_o) sb.note_request(in_item_i);
    end
  end

  function automatic logic [KEY_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [KEY_W-1:0] byte_mask(logic [LEN_W-1:0] klen);
    if (klen >= KEY_BYTES) return '1;
    return (KEY_W'(1) << (8 * klen)) - KEY_W'(1);
  endfunction

  task automatic offer(input logic [FUNC_W-1:0] f, input logic [KEY_W-1:0] k,
                       input logic [LEN_W-1:0] klen, input logic [VAL_W-1:0] v);
    in_item_t it;
    int       gap;
    it.func    = f;
    it.key     = k;
    it.key_len = klen;
    it.value   = v;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  initial begin : receiver
    int span;
    int duty;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        span = $urandom_range(1, 40);
        case ($urandom_range(0, 3))
          0:       duty = 100;
          1:       duty = 70;
          2:       duty = 30;
          default: duty = 5;
        endcase
        repeat (span) begin
          out_ready_i <= ($urandom_range(1, 100) <= duty);
          @(negedge clk_i);
        end
      end
    end
  end

  initial begin : stimulus
    in_item_t             pk;
    logic [FUNC_W-1:0]    f;
    logic [KEY_W-1:0]     k;
    logic [KEY_W-1:0]     fill_key;
    logic [LEN_W-1:0]     klen;
    int                   sel;
    int                   ins_w;
    int                   del_w;
    int                   r;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    sb = new();
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    offer(FUNC_FIND,   64'h0, 4'd3, 40'h0);
    offer(FUNC_UNDEF,  '1,    4'd8, '1);
    offer(FUNC_INSERT, '1,    4'd0, '1);
    offer(FUNC_FIND,   64'h1234, 4'd0, 40'h0);
    offer(FUNC_INSERT, '1,    4'd8, 40'h0);
    offer(FUNC_INSERT, '1,    4'd15, 40'h55_5555_5555);
    offer(FUNC_FIND,   '1,    4'd12, 40'h0);
    offer(FUNC_INSERT, 64'h0, 4'd1, 40'hAA_AAAA_AAAA);
    offer(FUNC_FIND,   64'hFFFF_FF00, 4'd1, 40'h0);
    offer(FUNC_DELETE, '1,    4'd9, 40'h0);
    offer(FUNC_FIND,   '1,    4'd8, 40'h0);
    offer(FUNC_INSERT, 64'h1234, 4'd2, 40'h1);
    offer(FUNC_DELETE, 64'h1234, 4'd2, 40'h0);
    fill_key = '0;
    for (int i = 0; i < 14; i++) begin
      k = rand64();
      if (i == 12) fill_key = k;
      offer(FUNC_INSERT, k, 4'd5, VAL_W'(rand64()));
    end
    offer(FUNC_FIND, fill_key, 4'd5, 40'h0);

    ins_w = 40;
    del_w = 25;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 200 == 0) begin
        ins_w = $urandom_range(20, 60);
        del_w = $urandom_range(10, 35);
      end
      if (n == 400) hold_req = 1'b1;
      if (n == 800) begin
        in_valid_i <= 1'b0;
        do @(negedge clk_i); while (sb.expected_replies.size() != 0);
      end
      sel = $urandom_range(1, 100);
      if (sel <= ins_w) f = FUNC_INSERT;
      else if (sel <= ins_w + del_w) f = FUNC_DELETE;
      else if (sel <= 97) f = FUNC_FIND;
      else f = FUNC_UNDEF;
      if (key_pool.size() > 0 &&
          $urandom_range(0, 99) < ((f == FUNC_INSERT) ? 15 : 75)) begin
        pk   = key_pool[$urandom_range(0, key_pool.size() - 1)];
        klen = pk.key_len;
        k    = pk.key;
        if ($urandom_range(0, 1)) k = (k & byte_mask(klen)) | (rand64() & ~byte_mask(klen));
        if (klen >= KEY_BYTES) klen = LEN_W'($urandom_range(8, 15));
      end else begin
        r = $urandom_range(0, 19);
        klen = (r == 0) ? 4'd0 : (r <= 16) ? LEN_W'($urandom_range(1, 8))
                                          : LEN_W'($urandom_range(9, 15));
        k = ($urandom_range(0, 2) == 0) ? KEY_W'($urandom_range(0, 3)) : rand64();
      end
      offer(f, k, klen, VAL_W'(rand64()));
      if (f == FUNC_INSERT) begin
        pk.func    = f;
        pk.key     = k;
        pk.key_len = klen;
        pk.value   = '0;
        key_pool.push_back(pk);
        if (key_pool.size() > 24) void'(key_pool.pop_front());
      end
    end

    in_valid_i <= 1'b0;
    while (sb.expected_replies.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (sb.fail_count == 0 && sb.expected_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: coalesced_chain_hash_dictionary.f
rtl/cchd_pkg.sv
rtl/cchd_datapath.sv
rtl/cchd_controller.sv
rtl/coalesced_chain_hash_dictionary.sv
sim/cchd_tb_pkg.sv
sim/coalesced_chain_hash_dictionary_tb.sv
